>>> design/clx_pkg.sv
// Shared types, codes and keyword table for the token lexer.
package clx_pkg;

    // Identifiers keep at most IDENT_CAPACITY-1 characters.
    localparam int IDENT_CAPACITY = 8;
    localparam logic [2:0] IDENT_MAX = 3'(IDENT_CAPACITY - 1);

    typedef enum logic [4:0] {
        TK_END        = 5'd0,
        TK_INTEGER    = 5'd1,
        TK_IDENT      = 5'd2,
        TK_KW_INT     = 5'd3,
        TK_KW_IF      = 5'd4,
        TK_KW_ELSE    = 5'd5,
        TK_KW_WHILE   = 5'd6,
        TK_KW_RETURN  = 5'd7,
        TK_MINUS      = 5'd8,
        TK_PLUS       = 5'd9,
        TK_MULTIPLY   = 5'd10,
        TK_DIVIDE     = 5'd11,
        TK_LPAREN     = 5'd12,
        TK_RPAREN     = 5'd13,
        TK_ASSIGN     = 5'd14,
        TK_EQUALS     = 5'd15,
        TK_SEMICOLON  = 5'd16,
        TK_UNKNOWN    = 5'd17
    } clx_kind_t;

    typedef enum logic [2:0] {
        CC_SPACE   = 3'd0,
        CC_NEWLINE = 3'd1,
        CC_DIGIT   = 3'd2,
        CC_ALPHA   = 3'd3,
        CC_SLASH   = 3'd4,
        CC_EQUALS  = 3'd5,
        CC_SINGLE  = 3'd6,
        CC_EOI     = 3'd7
    } clx_class_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_NUM     = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_SLASH   = 3'd3,
        MODE_EQ      = 3'd4,
        MODE_COMMENT = 3'd5
    } clx_mode_t;

    typedef struct packed {
        logic       end_of_input;
        logic [7:0] character;
    } clx_in_t;

    typedef struct packed {
        clx_kind_t   token_kind;
        logic [31:0] integer_value;
        logic [55:0] ident_text;
        logic [2:0]  ident_length;
        logic        last_of_run;
    } clx_out_t;

    // Classified item as it sits in the queue between front and back.
    typedef struct packed {
        clx_class_t cls;
        logic [7:0] ch;
        clx_kind_t  op_kind;
    } clx_entry_t;

    localparam logic [55:0] KW_INT_TEXT    = 56'h00_0000_0074_6E69;
    localparam logic [55:0] KW_IF_TEXT     = 56'h00_0000_0000_6669;
    localparam logic [55:0] KW_ELSE_TEXT   = 56'h00_0000_6573_6C65;
    localparam logic [55:0] KW_WHILE_TEXT  = 56'h00_0065_6C69_6877;
    localparam logic [55:0] KW_RETURN_TEXT = 56'h00_4E52_5554_4552;

    function automatic clx_kind_t keyword_kind(input logic [55:0] text,
                                               input logic [2:0]  len);
        clx_kind_t k;
        k = TK_IDENT;
        if (len == 3'd3 && text == KW_INT_TEXT) begin
            k = TK_KW_INT;
        end else if (len == 3'd2 && text == KW_IF_TEXT) begin
            k = TK_KW_IF;
        end else if (len == 3'd4 && text == KW_ELSE_TEXT) begin
            k = TK_KW_ELSE;
        end else if (len == 3'd5 && text == KW_WHILE_TEXT) begin
            k = TK_KW_WHILE;
        end else if (len == 3'd6 && text == KW_RETURN_TEXT) begin
            k = TK_KW_RETURN;
        end
        return k;
    endfunction

endpackage

>>> design/c_subset_token_lexer.sv
// Top level of the streaming lexer: front classifier, queue, scanner back end.
// One source byte (or an end-of-input mark) per item, one token per result item. Items are
// taken one per clock while the queue has room; an item that both closes a pending token and
// makes a token of its own (or an end mark after a pending token) yields two results and holds
// the scanner until the second moves to the output register, while the QUEUE_DEPTH-entry queue
// behind the front keeps taking items. The scanner state (mode, 32-bit accumulator, identifier
// buffer) is updated once per item, so that one state loop sets the rate. A token reaches m_
// only after its item has been written into the queue and then registered in the output stage.
module c_subset_token_lexer import clx_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  clx_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output clx_out_t m_data
);

    logic       push;
    logic       q_full;
    logic       q_valid;
    logic       pop;
    clx_entry_t push_entry;
    clx_entry_t q_entry;

    clx_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    clx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (push),
        .wr_entry (push_entry),
        .full     (q_full),
        .rd_en    (pop),
        .rd_valid (q_valid),
        .rd_entry (q_entry)
    );

    clx_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> design/clx_front.sv
// Front end: takes input items and classifies each character.
module clx_front import clx_pkg::*; (
    input  logic       s_valid,
    output logic       s_ready,
    input  clx_in_t    s_data,
    input  logic       q_full,
    output logic       push,
    output clx_entry_t push_entry
);

    logic [7:0] c;

    assign c       = s_data.character;
    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        push_entry.ch      = c;
        push_entry.op_kind = TK_UNKNOWN;
        push_entry.cls     = CC_SINGLE;
        priority if (s_data.end_of_input) begin
            push_entry.cls = CC_EOI;
        end else if (c == 8'h0A) begin
            push_entry.cls = CC_NEWLINE;
        end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            push_entry.cls = CC_SPACE;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            push_entry.cls = CC_DIGIT;
        end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
                     || c == 8'h5F) begin
            push_entry.cls = CC_ALPHA;
        end else if (c == 8'h2F) begin
            push_entry.cls = CC_SLASH;
        end else if (c == 8'h3D) begin
            push_entry.cls = CC_EQUALS;
        end else if (c == 8'h2D) begin
            push_entry.op_kind = TK_MINUS;
        end else if (c == 8'h2B) begin
            push_entry.op_kind = TK_PLUS;
        end else if (c == 8'h2A) begin
            push_entry.op_kind = TK_MULTIPLY;
        end else if (c == 8'h28) begin
            push_entry.op_kind = TK_LPAREN;
        end else if (c == 8'h29) begin
            push_entry.op_kind = TK_RPAREN;
        end else if (c == 8'h3B) begin
            push_entry.op_kind = TK_SEMICOLON;
        end else begin
            push_entry.op_kind = TK_UNKNOWN;
        end
    end

endmodule

>>> design/clx_queue.sv
// Short register queue between the classifying front and the scanning back.
module clx_queue import clx_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  clx_entry_t wr_entry,
    output logic       full,
    input  logic       rd_en,
    output logic       rd_valid,
    output clx_entry_t rd_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    clx_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && !rd_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

>>> design/clx_back.sv
// Back end: scanner state machine, token assembly and output staging.
module clx_back import clx_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  clx_entry_t q_entry,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output clx_out_t   m_data
);

    clx_mode_t   mode_reg, mode_next;
    logic [31:0] acc_reg, acc_next;
    logic [55:0] buf_reg, buf_next;
    logic [2:0]  count_reg, count_next;

    logic        m_valid_reg;
    clx_out_t    m_data_reg;
    logic        hold_valid_reg;
    clx_out_t    hold_reg;

    clx_out_t    flush_tok, start_tok, tok0, tok1;
    logic        flush_hit, start_hit;
    logic [1:0]  n_tok;
    logic        out_free;
    logic [31:0] acc_times_ten;
    logic        in_word;

    assign acc_times_ten = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};

    // True when the item continues the pending token instead of ending it.
    always_comb begin
        unique case (mode_reg)
            MODE_NUM:     in_word = (q_entry.cls == CC_DIGIT);
            MODE_IDENT:   in_word = (q_entry.cls == CC_ALPHA);
            MODE_SLASH:   in_word = (q_entry.cls == CC_SLASH);
            MODE_EQ:      in_word = (q_entry.cls == CC_EQUALS);
            MODE_COMMENT: in_word = 1'b1;
            default:      in_word = 1'b0;
        endcase
        if (q_entry.cls == CC_EOI) begin
            in_word = 1'b0;
        end
    end

    // Next scanner mode.
    always_comb begin
        mode_next = mode_reg;
        if (q_entry.cls == CC_EOI) begin
            mode_next = MODE_IDLE;
        end else if (in_word) begin
            unique case (mode_reg)
                MODE_SLASH:   mode_next = MODE_COMMENT;
                MODE_EQ:      mode_next = MODE_IDLE;
                MODE_COMMENT: mode_next = (q_entry.cls == CC_NEWLINE) ? MODE_IDLE
                                                                      : MODE_COMMENT;
                default:      mode_next = mode_reg;
            endcase
        end else begin
            unique case (q_entry.cls)
                CC_DIGIT:  mode_next = MODE_NUM;
                CC_ALPHA:  mode_next = MODE_IDENT;
                CC_SLASH:  mode_next = MODE_SLASH;
                CC_EQUALS: mode_next = MODE_EQ;
                default:   mode_next = MODE_IDLE;
            endcase
        end
    end

    // Tokens and datapath updates for the item at the head of the queue.
    always_comb begin
        flush_tok  = '0;
        start_tok  = '0;
        flush_hit  = 1'b0;
        start_hit  = 1'b0;
        acc_next   = acc_reg;
        buf_next   = buf_reg;
        count_next = count_reg;

        unique case (mode_reg)
            MODE_NUM: begin
                flush_hit               = 1'b1;
                flush_tok.token_kind    = TK_INTEGER;
                flush_tok.integer_value = acc_reg;
            end
            MODE_IDENT: begin
                flush_hit              = 1'b1;
                flush_tok.token_kind   = keyword_kind(buf_reg, count_reg);
                flush_tok.ident_text   = buf_reg;
                flush_tok.ident_length = count_reg;
            end
            MODE_SLASH: begin
                flush_hit            = 1'b1;
                flush_tok.token_kind = TK_DIVIDE;
            end
            MODE_EQ: begin
                flush_hit            = 1'b1;
                flush_tok.token_kind = TK_ASSIGN;
            end
            default: begin
                flush_hit = 1'b0;
            end
        endcase

        unique case (q_entry.cls)
            CC_DIGIT: begin
                acc_next = {28'd0, q_entry.ch[3:0]};
            end
            CC_ALPHA: begin
                buf_next   = {48'd0, q_entry.ch};
                count_next = 3'd1;
            end
            CC_SINGLE: begin
                start_hit            = 1'b1;
                start_tok.token_kind = q_entry.op_kind;
            end
            CC_EOI: begin
                start_hit            = 1'b1;
                start_tok.token_kind = TK_END;
                acc_next             = '0;
                buf_next             = '0;
                count_next           = '0;
            end
            default: begin
                start_hit = 1'b0;
            end
        endcase

        if (in_word) begin
            flush_hit  = 1'b0;
            start_hit  = 1'b0;
            acc_next   = acc_reg;
            buf_next   = buf_reg;
            count_next = count_reg;
            if (mode_reg == MODE_NUM) begin
                acc_next = acc_times_ten + {28'd0, q_entry.ch[3:0]};
            end else if (mode_reg == MODE_IDENT && count_reg < IDENT_MAX) begin
                buf_next[{count_reg, 3'b000} +: 8] = q_entry.ch;
                count_next = count_reg + 3'd1;
            end else if (mode_reg == MODE_EQ) begin
                start_hit            = 1'b1;
                start_tok.token_kind = TK_EQUALS;
            end
        end

        n_tok = {1'b0, flush_hit} + {1'b0, start_hit};
        tok0  = flush_hit ? flush_tok : start_tok;
        tok1  = start_tok;
        tok0.last_of_run = !(flush_hit && start_hit);
        tok1.last_of_run = 1'b1;
    end

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = q_valid && !hold_valid_reg && (n_tok == 2'd0 || out_free);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            acc_reg        <= '0;
            buf_reg        <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                mode_reg  <= mode_next;
                acc_reg   <= acc_next;
                buf_reg   <= buf_next;
                count_reg <= count_next;
            end
            if (out_free) begin
                if (hold_valid_reg) begin
                    m_valid_reg    <= 1'b1;
                    hold_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg    <= pop && (n_tok != 2'd0);
                    hold_valid_reg <= pop && (n_tok == 2'd2);
                end
            end
        end
    end

    // Payload staging; second token of a pair waits in the hold register.
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (hold_valid_reg) begin
                m_data_reg <= hold_reg;
            end else if (pop && n_tok != 2'd0) begin
                m_data_reg <= tok0;
                hold_reg   <= tok1;
            end
        end
    end

    a_hold_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> m_valid_reg)
        else $error("second token staged with no first token out");

    a_pair_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> !m_data_reg.last_of_run && hold_reg.last_of_run)
        else $error("last_of_run wrong on a token pair");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.token_kind == TK_END |-> m_data_reg.last_of_run)
        else $error("end token not marked last");

    a_eoi_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && q_entry.cls == CC_EOI |=> mode_reg == MODE_IDLE && count_reg == 3'd0)
        else $error("end of input did not return scanner to idle");

endmodule

>>> dv/tb_c_subset_token_lexer.sv
// Testbench for the token lexer: directed table, random source text, token predictor.
module tb_c_subset_token_lexer;
    import clx_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLDOFF_AT = 400;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int CALM_FIRST = 700;
    localparam int CALM_LAST = 900;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_EQUALS = "=";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_PLUS = "+";
    localparam logic [7:0] CH_STAR = "*";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_SEMI = ";";
    localparam logic [7:0] CH_ZERO = "0";

    typedef struct {
        clx_in_t   item;
        bit        typed;
        clx_kind_t kind;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    clx_in_t   s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    clx_out_t  m_data;

    // Sideband that travels with the offered item
    logic      offer_typed;
    clx_kind_t offer_kind;

    clx_mode_t   lex_mode = MODE_IDLE;
    logic [31:0] lex_acc = '0;
    logic [55:0] lex_text = '0;
    logic [2:0]  lex_len = '0;

    clx_out_t item_tokens[$];
    clx_out_t expected_tokens[$];
    clx_in_t  source_items[$];

    int mismatches = 0;
    int tokens_seen = 0;
    int items_in = 0;
    int cycle_count = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;

    stim_row_t directed_rows[25] = '{
        '{'{1'b1, 8'h00}, 1'b1, TK_END},
        '{'{1'b0, 8'h00}, 1'b1, TK_UNKNOWN},
        '{'{1'b0, 8'hFF}, 1'b1, TK_UNKNOWN},
        '{'{1'b0, "("}, 1'b1, TK_LPAREN},
        '{'{1'b0, ")"}, 1'b1, TK_RPAREN},
        '{'{1'b0, "+"}, 1'b1, TK_PLUS},
        '{'{1'b0, "-"}, 1'b1, TK_MINUS},
        '{'{1'b0, "*"}, 1'b1, TK_MULTIPLY},
        '{'{1'b0, ";"}, 1'b1, TK_SEMICOLON},
        '{'{1'b0, "="}, 1'b0, TK_END},
        '{'{1'b0, "="}, 1'b1, TK_EQUALS},
        '{'{1'b0, "="}, 1'b0, TK_END},
        '{'{1'b0, ";"}, 1'b0, TK_END},
        '{'{1'b0, "/"}, 1'b0, TK_END},
        '{'{1'b0, "/"}, 1'b0, TK_END},
        '{'{1'b0, 8'h0A}, 1'b0, TK_END},
        '{'{1'b0, "/"}, 1'b0, TK_END},
        '{'{1'b0, "7"}, 1'b0, TK_END},
        '{'{1'b0, "i"}, 1'b0, TK_END},
        '{'{1'b0, "f"}, 1'b0, TK_END},
        '{'{1'b0, " "}, 1'b0, TK_END},
        '{'{1'b0, "x"}, 1'b0, TK_END},
        '{'{1'b1, 8'hA5}, 1'b0, TK_END},
        '{'{1'b0, "/"}, 1'b0, TK_END},
        '{'{1'b1, 8'h5A}, 1'b0, TK_END}
    };

    c_subset_token_lexer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic clx_kind_t match_keyword(logic [55:0] text, logic [2:0] len);
        string     words[5] = '{"int", "if", "else", "while", "RETURN"};
        clx_kind_t kinds[5] = '{TK_KW_INT, TK_KW_IF, TK_KW_ELSE, TK_KW_WHILE, TK_KW_RETURN};
        logic [55:0] word_bits;
        for (int i = 0; i < 5; i++) begin
            word_bits = '0;
            for (int j = 0; j < words[i].len(); j++) begin
                word_bits[8*j +: 8] = words[i][j];
            end
            if (int'(len) == words[i].len() && text == word_bits) begin
                return kinds[i];
            end
        end
        return TK_IDENT;
    endfunction

    task automatic lex_emit(clx_kind_t k, logic [31:0] v, logic [55:0] t, logic [2:0] n);
        clx_out_t tok;
        tok.token_kind = k;
        tok.integer_value = v;
        tok.ident_text = t;
        tok.ident_length = n;
        tok.last_of_run = 1'b0;
        item_tokens.push_back(tok);
    endtask

    // Emit whatever token the current mode holds, then fall back to idle.
    task automatic lex_flush();
        case (lex_mode)
            MODE_NUM:   lex_emit(TK_INTEGER, lex_acc, '0, '0);
            MODE_IDENT: lex_emit(match_keyword(lex_text, lex_len), '0, lex_text, lex_len);
            MODE_SLASH: lex_emit(TK_DIVIDE, '0, '0, '0);
            MODE_EQ:    lex_emit(TK_ASSIGN, '0, '0, '0);
            default: ;
        endcase
        lex_mode = MODE_IDLE;
    endtask

    task automatic lex_start(logic [7:0] c);
        if (is_blank(c)) begin
        end else if (is_digit(c)) begin
            lex_mode = MODE_NUM;
            lex_acc = {24'd0, c - CH_ZERO};
        end else if (is_letter(c)) begin
            lex_mode = MODE_IDENT;
            lex_text = {48'd0, c};
            lex_len = 3'd1;
        end else begin
            case (c)
                CH_SLASH:  lex_mode = MODE_SLASH;
                CH_EQUALS: lex_mode = MODE_EQ;
                CH_MINUS:  lex_emit(TK_MINUS, '0, '0, '0);
                CH_PLUS:   lex_emit(TK_PLUS, '0, '0, '0);
                CH_STAR:   lex_emit(TK_MULTIPLY, '0, '0, '0);
                CH_LPAREN: lex_emit(TK_LPAREN, '0, '0, '0);
                CH_RPAREN: lex_emit(TK_RPAREN, '0, '0, '0);
                CH_SEMI:   lex_emit(TK_SEMICOLON, '0, '0, '0);
                default:   lex_emit(TK_UNKNOWN, '0, '0, '0);
            endcase
        end
    endtask

    // Advance the lexer by one item, leaving its tokens in item_tokens.
    task automatic lex_step(clx_in_t item);
        logic [7:0] c;
        clx_out_t   tok;
        c = item.character;
        item_tokens.delete();
        if (item.end_of_input) begin
            lex_flush();
            lex_emit(TK_END, '0, '0, '0);
            lex_mode = MODE_IDLE;
            lex_acc = '0;
            lex_text = '0;
            lex_len = '0;
        end else begin
            case (lex_mode)
                MODE_NUM: begin
                    if (is_digit(c)) begin
                        lex_acc = lex_acc * 32'd10 + {24'd0, c - CH_ZERO};
                    end else begin
                        lex_flush();
                        lex_start(c);
                    end
                end
                MODE_IDENT: begin
                    if (is_letter(c)) begin
                        // Drop characters beyond the buffer
                        if (int'(lex_len) < IDENT_CAPACITY - 1) begin
                            lex_text[8*lex_len +: 8] = c;
                            lex_len = lex_len + 3'd1;
                        end
                    end else begin
                        lex_flush();
                        lex_start(c);
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        lex_mode = MODE_COMMENT;
                    end else begin
                        lex_flush();
                        lex_start(c);
                    end
                end
                MODE_EQ: begin
                    if (c == CH_EQUALS) begin
                        lex_mode = MODE_IDLE;
                        lex_emit(TK_EQUALS, '0, '0, '0);
                    end else begin
                        lex_flush();
                        lex_start(c);
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_NEWLINE) lex_mode = MODE_IDLE;
                end
                default: begin
                    lex_mode = MODE_IDLE;
                    lex_start(c);
                end
            endcase
        end
        if (item_tokens.size() > 0) begin
            tok = item_tokens.pop_back();
            tok.last_of_run = 1'b1;
            item_tokens.push_back(tok);
        end
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_token(clx_out_t got);
        clx_out_t want;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("token %0d (kind %0d) with none expected",
                                      tokens_seen, got.token_kind));
        end else begin
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
                report_mismatch($sformatf("token %0d kind %0d, want %0d",
                                          tokens_seen, got.token_kind, want.token_kind));
            if (got.integer_value !== want.integer_value)
                report_mismatch($sformatf("token %0d value %0d, want %0d",
                                          tokens_seen, got.integer_value, want.integer_value));
            if (got.ident_text !== want.ident_text)
                report_mismatch($sformatf("token %0d text %h, want %h",
                                          tokens_seen, got.ident_text, want.ident_text));
            if (got.ident_length !== want.ident_length)
                report_mismatch($sformatf("token %0d length %0d, want %0d",
                                          tokens_seen, got.ident_length, want.ident_length));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("token %0d last flag %b, want %b",
                                          tokens_seen, got.last_of_run, want.last_of_run));
        end
        tokens_seen++;
    endtask

    // Predict on every accepted item, check every accepted token
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                lex_step(s_data);
                if (offer_typed) begin
                    expected_tokens.push_back('{offer_kind, 32'd0, 56'd0, 3'd0, 1'b1});
                end else begin
                    foreach (item_tokens[i]) expected_tokens.push_back(item_tokens[i]);
                end
                items_in <= items_in + 1;
            end
            if (m_valid && m_ready) check_token(m_data);
        end
    end

    // Receiver: random stalls, one long hold-off, one calm stretch
    always @(posedge aclk) begin
        if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            m_ready <= 1'b0;
        end else if (!holdoff_done && items_in == HOLDOFF_AT) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
            m_ready <= 1'b0;
        end else if (items_in >= CALM_FIRST && items_in < CALM_LAST) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 27);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[c_subset_token_lexer] ERROR");
            $finish;
        end
    end

    task automatic send_item(clx_in_t item, bit typed, clx_kind_t kind, bit calm);
        if (!calm) begin
            while ($urandom_range(99) < 27) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= item;
        offer_typed <= typed;
        offer_kind <= kind;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) source_items.push_back('{1'b0, s[i]});
    endtask

    // Append one random piece of source text; mostly well-formed tokens.
    task automatic add_random_chunk();
        string keywords[5] = '{"int", "if", "else", "while", "RETURN"};
        string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        string operators = "-+*/()=;";
        string blanks = " \t\n\r\v\f";
        int    pick;
        int    n;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 20) begin
            push_text(keywords[$urandom_range(4)]);
            if ($urandom_range(3) == 0) push_text("X_y");
        end else if (pick < 35) begin
            n = ($urandom_range(4) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
            repeat (n) source_items.push_back('{1'b0, letters[$urandom_range(52)]});
        end else if (pick < 50) begin
            n = ($urandom_range(4) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
            repeat (n) source_items.push_back('{1'b0, 8'(CH_ZERO + $urandom_range(9))});
        end else if (pick < 65) begin
            source_items.push_back('{1'b0, operators[$urandom_range(7)]});
        end else if (pick < 70) begin
            push_text("==");
        end else if (pick < 75) begin
            push_text("//");
            repeat ($urandom_range(6)) begin
                c = 8'($urandom_range(255));
                if (c == CH_NEWLINE) c = 8'h20;
                source_items.push_back('{1'b0, c});
            end
            if ($urandom_range(9) == 0) begin
                source_items.push_back('{1'b1, 8'($urandom_range(255))});
            end else begin
                source_items.push_back('{1'b0, CH_NEWLINE});
            end
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 3)) begin
                source_items.push_back('{1'b0, blanks[$urandom_range(5)]});
            end
        end else if (pick < 96) begin
            source_items.push_back('{1'b0, 8'($urandom_range(255))});
        end else begin
            source_items.push_back('{1'b1, 8'($urandom_range(255))});
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        offer_typed = 1'b0;
        offer_kind = TK_END;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].kind,
                      1'b0);
        end

        while (source_items.size() < RANDOM_ITEMS) add_random_chunk();
        source_items.push_back('{1'b1, 8'h00});
        foreach (source_items[i]) begin
            send_item(source_items[i], 1'b0, TK_END, i >= CALM_FIRST && i < CALM_LAST);
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (expected_tokens.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("[c_subset_token_lexer] OK");
        end else begin
            $display("[c_subset_token_lexer] ERROR");
        end
        $finish;
    end

endmodule

>>> c_subset_token_lexer.f
design/clx_pkg.sv
design/clx_front.sv
design/clx_queue.sv
design/clx_back.sv
design/c_subset_token_lexer.sv
dv/tb_c_subset_token_lexer.sv
